>>> sv/llq_pkg.sv
// ----------------------------------------------------------------------------
// llq_pkg
// Shared types and constants of the load latency queue.
// ----------------------------------------------------------------------------
package llq_pkg;

  localparam int DEPTH = 8;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  localparam logic [7:0] LATENCY_RST = 8'd4;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_AGE   = 2'd1;
  localparam logic [1:0] REQ_ISSUE = 2'd2;
  localparam logic [1:0] REQ_FLUSH = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  dest_reg;
    logic [31:0] load_address;
    logic [5:0]  rob_index;
  } in_word_t;

  typedef struct packed {
    logic        issued;
    logic [31:0] out_address;
    logic [5:0]  out_rob_index;
    logic [4:0]  out_dest_reg;
    logic        status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic step;   // apply the accepted word and latch its result
  } llq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } llq_stat_t;

endpackage

>>> sv/llq_ctrl.sv
// ----------------------------------------------------------------------------
// llq_ctrl
// Handshake controller: tracks whether the output register holds a word.
// ----------------------------------------------------------------------------
module llq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  llq_pkg::llq_stat_t stat,
  output llq_pkg::llq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_OUT  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign out_valid = (state_r == S_OUT);
  // output register frees up in the same cycle it is taken
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign cmd.step  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.step) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (cmd.step) state_nxt = S_OUT;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.empty && stat.full))
    else $error("queue reports empty and full at once");
`endif

endmodule

>>> sv/llq_dp.sv
// ----------------------------------------------------------------------------
// llq_dp
// Queue storage, pointers, ages, latency register and result register.
// ----------------------------------------------------------------------------
module llq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  llq_pkg::llq_cmd_t  cmd,
  output llq_pkg::llq_stat_t stat,
  input  llq_pkg::in_word_t  in_word,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  output llq_pkg::out_word_t out_word
);

  logic [31:0]               addr_r [llq_pkg::DEPTH];
  logic [4:0]                dest_r [llq_pkg::DEPTH];
  logic [5:0]                rob_r  [llq_pkg::DEPTH];
  logic [7:0]                age_r  [llq_pkg::DEPTH];
  logic [llq_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [llq_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [llq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]                lat_r;
  llq_pkg::out_word_t        out_word_r, out_word_nxt;

  logic full, empty, oldest_ready;
  logic do_add, do_age, do_issue;

  assign full  = (count_r == llq_pkg::CNT_FULL);
  assign empty = (count_r == '0);
  assign stat.full  = full;
  assign stat.empty = empty;

  assign oldest_ready = !empty && (age_r[tail_r] >= lat_r);

  assign do_add   = cmd.step && (in_word.req_type == llq_pkg::REQ_ADD) && !full;
  assign do_age   = cmd.step && (in_word.req_type == llq_pkg::REQ_AGE);
  assign do_issue = cmd.step && (in_word.req_type == llq_pkg::REQ_ISSUE) && oldest_ready;

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    out_word_nxt = '0;
    case (in_word.req_type)
      llq_pkg::REQ_ADD: begin
        if (full) begin
          out_word_nxt.status = 1'b1;
        end else begin
          head_nxt  = (head_r == llq_pkg::PTR_LAST) ? '0 : head_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      llq_pkg::REQ_AGE: begin
      end
      llq_pkg::REQ_ISSUE: begin
        if (oldest_ready) begin
          out_word_nxt.issued        = 1'b1;
          out_word_nxt.out_address   = addr_r[tail_r];
          out_word_nxt.out_rob_index = rob_r[tail_r];
          out_word_nxt.out_dest_reg  = dest_r[tail_r];
          tail_nxt  = (tail_r == llq_pkg::PTR_LAST) ? '0 : tail_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      llq_pkg::REQ_FLUSH: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      lat_r   <= llq_pkg::LATENCY_RST;
    end else begin
      if (cmd.step) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) lat_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) out_word_r <= out_word_nxt;
    if (do_add) begin
      addr_r[head_r] <= in_word.load_address;
      dest_r[head_r] <= in_word.dest_reg;
      rob_r[head_r]  <= in_word.rob_index;
    end
  end

  // free slots age too; they are rewritten with 1 on add
  always_ff @(posedge clk) begin
    for (int i = 0; i < llq_pkg::DEPTH; i++) begin
      if (do_add && (head_r == llq_pkg::PTR_W'(i))) begin
        age_r[i] <= 8'd1;
      end else if (do_age && (age_r[i] < lat_r)) begin
        age_r[i] <= age_r[i] + 8'd1;
      end
    end
  end

  assign out_word = out_word_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= llq_pkg::CNT_FULL)
    else $error("entry count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (head_r == tail_r))
    else $error("pointers disagree with empty/full count");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && (in_word.req_type == llq_pkg::REQ_ADD) && full)
    |=> (out_word_r.status && (count_r == $past(count_r)) && (head_r == $past(head_r))))
    else $error("add on full queue changed state");

  a_no_issue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && empty) |=> !out_word_r.issued)
    else $error("issue from empty queue");

  a_issue_moves_tail: assert property (@(posedge clk) disable iff (!rst_n)
    do_issue |=> (count_r == $past(count_r) - 1'b1))
    else $error("issue did not remove an entry");
`endif

endmodule

>>> sv/load_latency_queue.sv
// ----------------------------------------------------------------------------
// load_latency_queue
// Circular load queue with per-entry ages and a latency gate on issue.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : request words (add, age all, try issue oldest, flush) with a
//            valid/ready handshake. Every accepted word yields exactly one
//            result word on out_*.
//   out_*  : result word: issued load (address, ROB slot, dest register) or
//            zeros, plus status = 1 when an add was dropped on a full queue.
//   cfg_*  : cfg_we/cfg_data write the load latency (reset value LATENCY_RST); write
//            only while no result is pending.
// Timing: the result is registered and shows on out_* in the cycle after the request is taken.
//   Throughput is one word per cycle while results are taken: the queue update, the age row
//   update and the tail read all finish together into the result register.
// Stall: while out_valid is high and out_ready low, in_ready drops and the
//   result word holds; in_ready returns in the cycle the result is taken.
// Reset (rst_n, synchronous, active low): queue empty, pointers zero, latency
//   back to LATENCY_RST, no result pending. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module load_latency_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  llq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output llq_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);

  llq_pkg::llq_cmd_t  cmd;
  llq_pkg::llq_stat_t stat;

  llq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  llq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_word (out_word)
  );

endmodule
